/* hw/rtl/txc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// txc_pkg
// Shared types, constants and microcode for the text console writer.
// ---------------------------------------------------------------------------
package txc_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BLANK   = 8'h20;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  character;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_character;
    logic [7:0] read_attribute;
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
  } out_item_t;

  typedef logic [3:0] step_t;

  localparam step_t S_FETCH     = 4'd0;
  localparam step_t S_PUT       = 4'd1;
  localparam step_t S_NEWLINE   = 4'd2;
  localparam step_t S_SCR_INIT  = 4'd3;
  localparam step_t S_SCR_LOOP  = 4'd4;
  localparam step_t S_SCR_DRAIN = 4'd5;
  localparam step_t S_BLANK     = 4'd6;
  localparam step_t S_TAIL      = 4'd7;
  localparam step_t S_PUT_WR    = 4'd8;
  localparam step_t S_DONE      = 4'd9;
  localparam step_t S_CLEAR     = 4'd10;
  localparam step_t S_READ      = 4'd11;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_DISPATCH,
    COND_PUT_DIRECT,
    COND_ROW_NOT_LAST,
    COND_CNT_NOT_LAST,
    COND_NO_PRINT
  } cond_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_COLS,
    CNT_LAST_ROW,
    CNT_INC
  } cnt_op_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_COPY_READ,
    MEM_BLANK_WR,
    MEM_CHAR_WR,
    MEM_CELL_READ
  } mem_op_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    cnt_op_t cnt_op;
    mem_op_t mem_op;
    logic    newline;
    logic    advance;
    logic    done;
  } ucw_t;

  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    w = '{cond: COND_ALWAYS, target: S_FETCH, cnt_op: CNT_HOLD, mem_op: MEM_NONE,
          newline: 1'b0, advance: 1'b0, done: 1'b0};
    unique case (step)
      S_FETCH: begin
        w.cond = COND_DISPATCH;
      end
      S_PUT: begin
        w.cond   = COND_PUT_DIRECT;
        w.target = S_PUT_WR;
      end
      S_NEWLINE: begin
        w.cond    = COND_ROW_NOT_LAST;
        w.target  = S_TAIL;
        w.newline = 1'b1;
      end
      S_SCR_INIT: begin
        w.target = S_SCR_LOOP;
        w.cnt_op = CNT_COLS;
      end
      S_SCR_LOOP: begin
        w.cond   = COND_CNT_NOT_LAST;
        w.target = S_SCR_LOOP;
        w.cnt_op = CNT_INC;
        w.mem_op = MEM_COPY_READ;
      end
      S_SCR_DRAIN: begin
        w.target = S_BLANK;
        w.cnt_op = CNT_LAST_ROW;
      end
      S_BLANK: begin
        w.cond   = COND_CNT_NOT_LAST;
        w.target = S_BLANK;
        w.cnt_op = CNT_INC;
        w.mem_op = MEM_BLANK_WR;
      end
      S_TAIL: begin
        w.cond   = COND_NO_PRINT;
        w.target = S_DONE;
      end
      S_PUT_WR: begin
        w.target  = S_DONE;
        w.mem_op  = MEM_CHAR_WR;
        w.advance = 1'b1;
      end
      S_DONE: begin
        w.target = S_FETCH;
        w.done   = 1'b1;
      end
      S_CLEAR: begin
        w.target = S_BLANK;
        w.cnt_op = CNT_ZERO;
      end
      S_READ: begin
        w.target = S_DONE;
        w.mem_op = MEM_CELL_READ;
      end
      default: begin
        w.target = S_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input logic [1:0] action);
    step_t s;
    unique case (action)
      ACT_PUT:   s = S_PUT;
      ACT_CLEAR: s = S_CLEAR;
      ACT_READ:  s = S_READ;
      default:   s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/txc_cell_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// txc_cell_ram
// Cell store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module txc_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store with cursor, put, clear, scroll and read,
// sequenced by a microcode table driving a counter and a cell RAM datapath.
// one transaction at a time, the next one accepted in the cycle the result is
//   offered at the earliest; the one-cell-per-cycle walk of scroll and clear dominates
// reset: cursor to row 0 column 0, foreground 15, background 0; cells untouched
// ---------------------------------------------------------------------------
module text_console_writer
  import txc_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS + 1);

  localparam logic [AW-1:0] CNT_LAST = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] CNT_COLS_V = AW'(COLUMNS);
  localparam logic [AW-1:0] CNT_ROW_BASE = AW'(CELL_COUNT - COLUMNS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_END = CW'(COLUMNS);

  step_t         step_r, step_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [3:0]    fg_r, bg_r;
  logic [7:0]    char_r;
  logic [AW-1:0] idx_r;
  logic          print_r;
  logic          rd_ok_r;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  ucw_t          uc;
  logic          in_acc;
  logic          take;
  logic          idx_ok;
  logic [7:0]    attr;
  logic [AW-1:0] put_addr;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  assign uc       = ucode_rom(step_r);
  assign in_stall = (step_r != S_FETCH) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = 32'(in_data.cell_index) < CELL_COUNT;
  assign attr     = {bg_r, fg_r};
  assign put_addr = AW'(32'(row_r) * COLUMNS + 32'(col_r));

  always_comb begin
    unique case (uc.cond)
      COND_ALWAYS:       take = 1'b1;
      COND_PUT_DIRECT:   take = (char_r != CHAR_NEWLINE) && (col_r < COL_END);
      COND_ROW_NOT_LAST: take = row_r != ROW_LAST;
      COND_CNT_NOT_LAST: take = cnt_r != CNT_LAST;
      COND_NO_PRINT:     take = !print_r;
      default:           take = 1'b0;
    endcase
    if (uc.cond == COND_DISPATCH) begin
      step_nxt = in_acc ? dispatch(in_data.action) : step_r;
    end else begin
      step_nxt = take ? uc.target : step_r + 4'd1;
    end
  end

  always_comb begin
    unique case (uc.cnt_op)
      CNT_HOLD:     cnt_nxt = cnt_r;
      CNT_ZERO:     cnt_nxt = '0;
      CNT_COLS:     cnt_nxt = CNT_COLS_V;
      CNT_LAST_ROW: cnt_nxt = CNT_ROW_BASE;
      CNT_INC:      cnt_nxt = AW'(cnt_r + 1'b1);
      default:      cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (uc.newline) begin
      col_nxt = '0;
      if (row_r != ROW_LAST) begin
        row_nxt = RW'(row_r + 1'b1);
      end
    end else if (uc.advance) begin
      col_nxt = CW'(col_r + 1'b1);
    end
  end

  // copy write lands in the cycle after its read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = put_addr;
    ram_wdata = {attr, char_r};
    priority if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata;
    end else if (uc.mem_op == MEM_BLANK_WR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
      ram_wdata = {attr, CHAR_BLANK};
    end else if (uc.mem_op == MEM_CHAR_WR) begin
      ram_we = 1'b1;
    end
    ram_re    = (uc.mem_op == MEM_COPY_READ) || (uc.mem_op == MEM_CELL_READ && rd_ok_r);
    ram_raddr = (uc.mem_op == MEM_COPY_READ) ? cnt_r : idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_FETCH;
      row_r       <= '0;
      col_r       <= '0;
      fg_r        <= 4'd15;
      bg_r        <= 4'd0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      wr_pend_r <= uc.mem_op == MEM_COPY_READ;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FOREGROUND: fg_r <= cfg_wdata;
          CFG_BACKGROUND: bg_r <= cfg_wdata;
          default:        fg_r <= fg_r;
        endcase
      end
      if (uc.done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    wr_addr_r <= AW'(cnt_r - CNT_COLS_V);
    if (in_acc) begin
      char_r   <= in_data.character;
      idx_r    <= AW'(in_data.cell_index);
      print_r  <= (in_data.action == ACT_PUT) && (in_data.character != CHAR_NEWLINE);
      rd_ok_r  <= (in_data.action == ACT_READ) && idx_ok;
    end
    if (uc.done) begin
      out_data_r.read_character <= rd_ok_r ? ram_rdata[7:0] : 8'd0;
      out_data_r.read_attribute <= rd_ok_r ? ram_rdata[15:8] : 8'd0;
      out_data_r.cursor_row     <= 5'(row_r);
      out_data_r.cursor_column  <= 7'(col_r);
    end
  end

  txc_cell_ram #(
    .DEPTH(CELL_COUNT),
    .AW   (AW)
  ) u_cell_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. A queue-fed driver
// offers put, clear, read and unused-action transactions. A monitor predicts
// every report from its own copy of the cell store, cursor and colors, and
// checks each report field by field. Both sides idle at random, and the
// receiver holds off for a long stretch at least once. Phases change the
// colors, the extremes among them.
// ---------------------------------------------------------------------------
module tb_top
  import txc_pkg::*;
();

  localparam int COLUMNS = COLUMNS_DEF;
  localparam int ROWS    = ROWS_DEF;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_AT      = 40;
  localparam int CYCLE_LIMIT  = (PHASES * PHASE_ITEMS + 200) * (CELLS + 20) * 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = CFG_FOREGROUND;
  logic [3:0] cfg_wdata = 4'd0;

  text_console_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // console state as the block should hold it
  logic [15:0] screen_model [0:CELLS-1];
  int          row_model;
  int          col_model;
  logic [3:0]  fg_model = 4'd15;
  logic [3:0]  bg_model = 4'd0;

  in_item_t  console_requests [$];
  out_item_t expected_reports [$];

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   hold_left = 0;
  int   results_seen = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   sender_quiet = 1'b0;
  bit   receiver_quiet = 1'b0;

  function automatic logic [15:0] blank_cell();
    return {bg_model, fg_model, CHAR_BLANK};
  endfunction

  function automatic void line_feed();
    col_model = 0;
    if (row_model < ROWS - 1) begin
      row_model++;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = blank_cell();
    end
  endfunction

  function automatic out_item_t console_step(input in_item_t req);
    out_item_t rep;
    rep = '0;
    case (req.action)
      ACT_PUT: begin
        if (req.character == CHAR_NEWLINE) begin
          line_feed();
        end else begin
          if (col_model > COLUMNS - 1) line_feed();
          screen_model[row_model * COLUMNS + col_model] = {bg_model, fg_model, req.character};
          col_model++;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = blank_cell();
      end
      ACT_READ: begin
        if (req.cell_index < CELLS) begin
          rep.read_character = screen_model[req.cell_index][7:0];
          rep.read_attribute = screen_model[req.cell_index][15:8];
        end
      end
      default: begin
      end
    endcase
    rep.cursor_row    = row_model[4:0];
    rep.cursor_column = col_model[6:0];
    return rep;
  endfunction

  function automatic void flag_mismatch(input string what, input out_item_t want,
                                        input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected char %h attr %h row %0d col %0d, got char %h attr %h row %0d col %0d",
               what, want.read_character, want.read_attribute, want.cursor_row,
               want.cursor_column, got.read_character, got.read_attribute,
               got.cursor_row, got.cursor_column);
  endfunction

  function automatic void queue_request(input logic [1:0] action, input logic [7:0] ch,
                                        input logic [10:0] idx);
    in_item_t req;
    req.action     = action;
    req.character  = ch;
    req.cell_index = idx;
    console_requests.push_back(req);
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int pick;
    pick           = $urandom_range(0, 99);
    req.character  = 8'($urandom_range(0, 255));
    req.cell_index = 11'($urandom_range(0, 2047));
    if (pick < 1) begin
      req.action = ACT_CLEAR;
    end else if (pick < 3) begin
      req.action = ACT_UNUSED;
    end else if (pick < 22) begin
      req.action = ACT_READ;
      if ($urandom_range(0, 15) == 0) req.cell_index = 11'($urandom_range(CELLS, 2047));
      else req.cell_index = 11'($urandom_range(0, CELLS - 1));
    end else begin
      req.action = ACT_PUT;
      if ($urandom_range(0, 11) == 0) req.character = CHAR_NEWLINE;
    end
    return req;
  endfunction

  // monitor: prediction on input transactions, checking on output transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) expected_reports.push_back(console_step(in_data));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected report", '0, out_data);
        end else if (out_data.read_character !== expected_reports[0].read_character ||
                     out_data.read_attribute !== expected_reports[0].read_attribute ||
                     out_data.cursor_row !== expected_reports[0].cursor_row ||
                     out_data.cursor_column !== expected_reports[0].cursor_column) begin
          flag_mismatch("report mismatch", expected_reports[0], out_data);
          void'(expected_reports.pop_front());
        end else begin
          void'(expected_reports.pop_front());
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid && !in_fire;
      if (in_fire) send_wait = sender_quiet ? 0 : $urandom_range(0, 5);
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (console_requests.size() > 0) begin
          in_data <= console_requests.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // receiver stalls, with a long hold-off early in the run and occasional ones at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        recv_wait = receiver_quiet ? 0 : $urandom_range(0, 5);
        if (results_seen == HOLD_AT || $urandom_range(0, 599) == 0)
          hold_left = $urandom_range(200, 400);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (console_requests.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FOREGROUND;
    cfg_wdata <= fg;
    fg_model  = fg;
    @(negedge clk);
    cfg_index <= CFG_BACKGROUND;
    cfg_wdata <= bg;
    bg_model  = bg;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [3:0] fg_pick;
    logic [3:0] bg_pick;
    for (int i = 0; i < CELLS; i++) screen_model[i] = 16'h0000;
    row_model = 0;
    col_model = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: store is cleared before anything reads it
    queue_request(ACT_CLEAR, 8'h00, 11'h000);
    queue_request(ACT_READ, 8'h00, 11'd0);
    queue_request(ACT_PUT, 8'h41, 11'h000);
    queue_request(ACT_PUT, 8'h00, 11'h7FF);
    queue_request(ACT_PUT, 8'hFF, 11'h000);
    queue_request(ACT_PUT, CHAR_NEWLINE, 11'h000);
    queue_request(ACT_PUT, 8'h7F, 11'h555);
    queue_request(ACT_READ, 8'hFF, 11'd0);
    queue_request(ACT_READ, 8'h00, 11'd1);
    queue_request(ACT_READ, 8'h00, 11'd2);
    queue_request(ACT_READ, 8'h00, 11'(COLUMNS));
    queue_request(ACT_READ, 8'h00, 11'(CELLS - 1));
    queue_request(ACT_READ, 8'h00, 11'(CELLS));
    queue_request(ACT_READ, 8'hAA, 11'h7FF);
    queue_request(ACT_UNUSED, 8'hFF, 11'h7FF);
    queue_request(ACT_UNUSED, 8'h00, 11'h000);
    queue_request(ACT_PUT, 8'h80, 11'h7FF);
    queue_request(ACT_CLEAR, 8'hFF, 11'h7FF);
    queue_request(ACT_READ, 8'h00, 11'd1);
    queue_request(ACT_PUT, 8'h20, 11'h2AA);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fg_pick = 4'd0;  bg_pick = 4'd0;  end
        1: begin fg_pick = 4'd15; bg_pick = 4'd15; end
        2: begin fg_pick = 4'd0;  bg_pick = 4'd15; end
        3: begin fg_pick = 4'd15; bg_pick = 4'd0;  end
        default: begin
          fg_pick = 4'($urandom_range(0, 15));
          bg_pick = 4'($urandom_range(0, 15));
        end
      endcase
      set_colors(fg_pick, bg_pick);
      sender_quiet   = (p % 3 == 2);
      receiver_quiet = (p % 4 == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) console_requests.push_back(random_request());
      wait_drained();
    end

    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/txc_pkg.sv
hw/rtl/txc_cell_ram.sv
hw/rtl/text_console_writer.sv
tb/tb_top.sv
